// ----- rtl/core/stprs_pkg.sv -----
// shared constants, types and state encoding for the segment tree block
// no dependencies; imported by every module of the block
`default_nettype none

package stprs_pkg;

  localparam int LEAVES = 1024;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 64;
  localparam int ADDR_W = $clog2(2 * LEAVES);
  localparam int CNT_W  = ADDR_W + 1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_STEP,
    ST_QRY_STEP,
    ST_QRY_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic upd_start;
    logic upd_step;
    logic qry_start;
    logic qry_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic pos_ok;
    logic upd_last;
    logic qry_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/segment_tree_point_update_range_sum.sv -----
// update: accepted in the idle cycle, then one parent sum per level; the next item is
//   taken once the root has been written, one write per level
// query: walk of up to log2(LEAVES) + 1 levels with two registered memory reads each,
//   then the sum is loaded into the result register; the next item is taken after
//   the load, later while the previous result still waits
// reset: synchronous, active low; a clearing pass over all 2*LEAVES nodes zeroes
//   the node memory while no item is accepted
`default_nettype none

module segment_tree_point_update_range_sum (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // item channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_cmd,
  input  wire logic [stprs_pkg::IDX_W-1:0]   in_first_index,
  input  wire logic [stprs_pkg::IDX_W-1:0]   in_last_index,
  input  wire logic [stprs_pkg::VAL_W-1:0]   in_new_value,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [stprs_pkg::SUM_W-1:0]   out_range_sum
);
  import stprs_pkg::*;

  // command and status bundles between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: clear sweep, idle, update walk, query walk, result hand-off
  stprs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: node memory with one write and two read ports, walk registers,
  // running sum and the output register that lets a new item in while a
  // result waits
  stprs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_new_value   (in_new_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_range_sum  (out_range_sum)
  );

endmodule

`default_nettype wire

// ----- rtl/core/stprs_dp.sv -----
// datapath: node sum memory, tree walk registers, accumulator, result register
// depends on stprs_pkg
`default_nettype none

module stprs_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [stprs_pkg::IDX_W-1:0]    in_first_index,
  input  wire logic [stprs_pkg::IDX_W-1:0]    in_last_index,
  input  wire logic [stprs_pkg::VAL_W-1:0]    in_new_value,
  input  wire stprs_pkg::dp_cmd_t             cmd,
  output stprs_pkg::dp_stat_t                 stat,
  output logic      [stprs_pkg::SUM_W-1:0]    out_range_sum
);
  import stprs_pkg::*;

  sum_t  mem [2*LEAVES];

  logic  we;
  addr_t waddr;
  sum_t  wdata;
  addr_t raddr_a;
  addr_t raddr_b;
  sum_t  rdata_a_r;
  sum_t  rdata_b_r;

  addr_t clr_r, clr_nxt;
  addr_t node_r, node_nxt;
  sum_t  cur_r, cur_nxt;
  cnt_t  a_r, a_nxt;
  cnt_t  b_r, b_nxt;
  logic  va_r, va_nxt;
  logic  vb_r, vb_nxt;
  sum_t  acc_r, acc_nxt;
  sum_t  res_r, res_nxt;

  cnt_t  lo;
  cnt_t  hi;
  cnt_t  b_dec;
  addr_t leaf_addr;
  addr_t parent;
  sum_t  leaf_val;
  sum_t  step_sum;
  sum_t  add_a;
  sum_t  add_b;

  assign lo        = CNT_W'(in_first_index);
  assign hi        = (32'(in_last_index) >= 32'(LEAVES)) ? CNT_W'(LEAVES - 1)
                                                       : CNT_W'(in_last_index);
  assign b_dec     = b_r - CNT_W'(1);
  assign leaf_addr = ADDR_W'(LEAVES) + ADDR_W'(in_first_index);
  assign parent    = node_r >> 1;
  assign leaf_val  = {{(SUM_W-VAL_W){in_new_value[VAL_W-1]}}, in_new_value};
  assign step_sum  = cur_r + rdata_a_r;
  assign add_a     = va_r ? rdata_a_r : '0;
  assign add_b     = vb_r ? rdata_b_r : '0;

  assign stat.clr_done = (clr_r == '1);
  assign stat.pos_ok   = (32'(in_first_index) < 32'(LEAVES));
  assign stat.upd_last = (parent == ADDR_W'(1));
  assign stat.qry_busy = (a_r < b_r);

  assign out_range_sum = res_r;

  always_comb begin
    we       = 1'b0;
    waddr    = node_r;
    wdata    = cur_r;
    raddr_a  = a_r[ADDR_W-1:0];
    raddr_b  = b_dec[ADDR_W-1:0];
    clr_nxt  = clr_r;
    node_nxt = node_r;
    cur_nxt  = cur_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    va_nxt   = 1'b0;
    vb_nxt   = 1'b0;
    acc_nxt  = acc_r + add_a + add_b;
    res_nxt  = res_r;

    if (cmd.clr_step) begin
      we      = 1'b1;
      waddr   = clr_r;
      wdata   = '0;
      clr_nxt = clr_r + ADDR_W'(1);
    end

    // leaf write, then fetch its sibling for the first parent sum
    if (cmd.upd_start) begin
      we       = stat.pos_ok;
      waddr    = leaf_addr;
      wdata    = leaf_val;
      raddr_a  = leaf_addr ^ ADDR_W'(1);
      node_nxt = leaf_addr;
      cur_nxt  = leaf_val;
    end

    // parent = current + sibling, fetch the next sibling in the same cycle
    if (cmd.upd_step) begin
      we       = 1'b1;
      waddr    = parent;
      wdata    = step_sum;
      cur_nxt  = step_sum;
      node_nxt = parent;
      raddr_a  = parent ^ ADDR_W'(1);
    end

    if (cmd.qry_start) begin
      acc_nxt = '0;
      if (lo <= hi) begin
        a_nxt = lo + CNT_W'(LEAVES);
        b_nxt = hi + CNT_W'(LEAVES) + CNT_W'(1);
      end else begin
        a_nxt = '0;
        b_nxt = '0;
      end
    end

    // half-open walk: odd left bound and odd right bound each take one node
    if (cmd.qry_step && stat.qry_busy) begin
      raddr_a = a_r[ADDR_W-1:0];
      raddr_b = b_dec[ADDR_W-1:0];
      va_nxt  = a_r[0];
      vb_nxt  = b_r[0];
      a_nxt   = (a_r + CNT_W'(a_r[0])) >> 1;
      b_nxt   = b_r >> 1;
    end

    if (cmd.out_load) begin
      res_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      a_r   <= '0;
      b_r   <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      clr_r <= clr_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      va_r  <= va_nxt;
      vb_r  <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    cur_r  <= cur_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/stprs_ctrl.sv -----
// controller: state machine sequencing clear, update and query walks
// depends on stprs_pkg; drives the datapath through dp_cmd_t
`default_nettype none

module stprs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_cmd,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output stprs_pkg::dp_cmd_t   cmd,
  input  wire stprs_pkg::dp_stat_t stat
);
  import stprs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_QUERY) begin
            state_nxt = ST_QRY_STEP;
          end else if (stat.pos_ok) begin
            state_nxt = ST_UPD_STEP;
          end
        end
      end
      ST_UPD_STEP: begin
        if (stat.upd_last) state_nxt = ST_IDLE;
      end
      ST_QRY_STEP: begin
        if (!stat.qry_busy) state_nxt = ST_QRY_DONE;
      end
      ST_QRY_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.upd_start = in_valid && (in_cmd == CMD_UPDATE);
        cmd.qry_start = in_valid && (in_cmd == CMD_QUERY);
      end
      ST_UPD_STEP: begin
        cmd.upd_step = 1'b1;
      end
      ST_QRY_STEP: begin
        cmd.qry_step = 1'b1;
      end
      ST_QRY_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result is only loaded when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending item");

  // a new result only ever comes from a load
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // at most one datapath operation per cycle
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.upd_start, cmd.upd_step,
              cmd.qry_start, cmd.qry_step, cmd.out_load}))
    else $error("conflicting datapath commands");

  // the query walk has finished once the result is due
  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRY_DONE) |-> !stat.qry_busy)
    else $error("query walk still running at result time");

endmodule

`default_nettype wire
